### rtl/mkra_pkg.sv
// Shared types and constants for the masked-key row address lookup.
package mkra_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned WORDS_W = 10;
   localparam int unsigned BYTES_W = 13;
   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned MAX_SLOTS = 16;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [KEY_W-1:0] END_MARK = '1;
   localparam logic [WORDS_W:0] HEADER_WORDS = 11'd3;

   typedef struct packed {
      logic [KEY_W-1:0]   id;
      logic [KEY_W-1:0]   mask;
      logic [KEY_W-1:0]   base;
      logic [WORDS_W-1:0] row_words;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{
      id:        END_MARK,
      mask:      '0,
      base:      '0,
      row_words: '0
   };

endpackage

### rtl/mkra_table.sv
// Entry table: per-slot valid bits, one write port, one registered read port.
module mkra_table #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IDX_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  mkra_pkg::entry_type wr_entry,
   input  logic [IDX_W-1:0]    rd_idx,
   output mkra_pkg::entry_type rd_entry
);
   import mkra_pkg::*;

   logic [DEPTH-1:0] valid_ff;
   entry_type        store_ff [DEPTH];
   entry_type        rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_entry;
      end
   end

   // Slots never written read as the empty entry (end mark).
   always_ff @(posedge clock) begin
      if (valid_ff[rd_idx]) begin
         rd_entry_ff <= store_ff[rd_idx];
      end else begin
         rd_entry_ff <= EMPTY_ENTRY;
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

### rtl/mkra_seq.sv
// Sequencer: scans entries through one comparator, then multiplies and adds.
module mkra_seq #(
   parameter int unsigned DEPTH        = 16,
   parameter int unsigned IDX_W        = 4,
   parameter int unsigned HEADER_BYTES = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [mkra_pkg::SLOT_W-1:0]      req_entry_index,
   input  logic [mkra_pkg::KEY_W-1:0]       req_key,
   output logic                             wr_en,
   output logic [IDX_W-1:0]                 wr_idx,
   output logic [IDX_W-1:0]                 rd_idx,
   input  mkra_pkg::entry_type              rd_entry,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [mkra_pkg::KEY_W-1:0]       rsp_row_address,
   output logic [mkra_pkg::BYTES_W-1:0]     rsp_row_bytes
);
   import mkra_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [SLOT_W:0]   DEPTH_LIM = (SLOT_W + 1)'(DEPTH);
   localparam logic [BYTES_W-1:0] HDR = BYTES_W'(HEADER_BYTES);

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   offset_ff, offset_in;
   logic [KEY_W-1:0]   base_ff, base_in;
   logic [BYTES_W-1:0] stride_ff, stride_in;
   logic [KEY_W-1:0]   product_ff, product_in;
   logic               hit_ff, hit_in;
   logic [KEY_W-1:0]   addr_ff, addr_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   logic accept;
   logic is_end;
   logic is_match;
   logic [WORDS_W:0] words_hdr;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_command == CMD_WRITE)
                      && ({1'b0, req_entry_index} < DEPTH_LIM);
   assign wr_idx    = IDX_W'(req_entry_index);
   assign rd_idx    = idx_in;

   assign is_end    = (rd_entry.id == END_MARK);
   assign is_match  = ((rd_entry.mask & key_ff) == rd_entry.id);
   assign words_hdr = {1'b0, rd_entry.row_words} + HEADER_WORDS;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      offset_in  = offset_ff;
      base_in    = base_ff;
      stride_in  = stride_ff;
      product_in = product_ff;
      hit_in     = hit_ff;
      addr_in    = addr_ff;
      bytes_in   = bytes_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && (req_command == CMD_LOOKUP)) begin
               key_in   = req_key;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (is_end) begin
               hit_in   = 1'b0;
               addr_in  = '0;
               bytes_in = '0;
               state_in = S_DONE;
            end else if (is_match) begin
               hit_in    = 1'b1;
               offset_in = key_ff & ~rd_entry.mask;
               base_in   = rd_entry.base;
               stride_in = {1'b0, rd_entry.row_words, 2'b00} + HDR;
               bytes_in  = {words_hdr, 2'b00};
               state_in  = S_MUL;
            end else if (idx_ff == LAST_IDX) begin
               hit_in   = 1'b0;
               addr_in  = '0;
               bytes_in = '0;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            product_in = KEY_W'(offset_ff * stride_ff);
            state_in   = S_ADD;
         end
         S_ADD: begin
            addr_in  = base_ff + product_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      offset_ff  <= offset_in;
      base_ff    <= base_in;
      stride_ff  <= stride_in;
      product_ff <= product_in;
      hit_ff     <= hit_in;
      addr_ff    <= addr_in;
      bytes_ff   <= bytes_in;
   end

   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_hit         = hit_ff;
   assign rsp_row_address = addr_ff;
   assign rsp_row_bytes   = bytes_ff;

endmodule

### rtl/masked_key_row_address_lookup.sv
// Top level of the masked-key row address lookup.
//
// Usage:
//   Request channel (req_*): one beat per command. A write beat
//   (req_command = 0) stores id, mask, base and row length in slot
//   req_entry_index and returns nothing; a slot at or beyond the table
//   depth is dropped. A lookup beat (req_command = 1) scans the table from
//   slot 0 and returns exactly one rsp_* beat.
//   Scan rule: stop at the first entry whose id is all ones; the first
//   entry with (mask & key) == id hits. row_address = base +
//   (key & ~mask) * (row_words*4 + HEADER_BYTES), wrapping at 32 bits;
//   row_bytes = (row_words+3)*4. A miss returns hit, address and bytes 0.
//   Timing: req_ready stays high through a write. A lookup
//   holds req_ready low; the single comparator visits one entry per
//   cycle. On a miss rsp_valid rises once the scan ends; on a hit the
//   product and then the sum are registered first (multiply, then add).
//   Stall: the response holds in its output register while rsp_ready is
//   low; req_ready returns the cycle after the response beat is taken.
//   Reset: clears all slot valid bits, so every slot reads as an end mark.
module masked_key_row_address_lookup #(
   parameter int unsigned TABLE_DEPTH  = 16,
   parameter int unsigned HEADER_BYTES = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [mkra_pkg::SLOT_W-1:0]    req_entry_index,
   input  logic [mkra_pkg::KEY_W-1:0]     req_entry_id,
   input  logic [mkra_pkg::KEY_W-1:0]     req_entry_mask,
   input  logic [mkra_pkg::KEY_W-1:0]     req_entry_base,
   input  logic [mkra_pkg::WORDS_W-1:0]   req_entry_row_words,
   input  logic [mkra_pkg::KEY_W-1:0]     req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic [mkra_pkg::KEY_W-1:0]     rsp_row_address,
   output logic [mkra_pkg::BYTES_W-1:0]   rsp_row_bytes
);
   import mkra_pkg::*;

   // Only slots reachable by the 4-bit write index can hold anything;
   // slots beyond that always read as end marks, so they need no storage.
   localparam int unsigned EFF_DEPTH =
      (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
   localparam int unsigned IDX_W = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   entry_type        wr_entry;
   entry_type        rd_entry;

   assign wr_entry = '{
      id:        req_entry_id,
      mask:      req_entry_mask,
      base:      req_entry_base,
      row_words: req_entry_row_words
   };

   mkra_table #(
      .DEPTH (EFF_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry)
   );

   mkra_seq #(
      .DEPTH        (EFF_DEPTH),
      .IDX_W        (IDX_W),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_key         (req_key),
      .wr_en           (wr_en),
      .wr_idx          (wr_idx),
      .rd_idx          (rd_idx),
      .rd_entry        (rd_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_row_address (rsp_row_address),
      .rsp_row_bytes   (rsp_row_bytes)
   );

endmodule

### rtl/mkra_checker.sv
// Port-level checks for the masked-key row address lookup, with bind.
module mkra_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_command,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_hit,
   input logic [mkra_pkg::KEY_W-1:0]     rsp_row_address,
   input logic [mkra_pkg::BYTES_W-1:0]   rsp_row_bytes
);
   import mkra_pkg::*;

   // Hold a stalled response beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_row_address) && $stable(rsp_row_bytes))
      else $error("stalled response changed");

   // A miss carries zero address and size.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_row_address == '0 && rsp_row_bytes == '0)
      else $error("miss with nonzero payload");

   // A hit covers at least the header words and is word aligned.
   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_row_bytes >= 13'd12 && rsp_row_bytes[1:0] == 2'b00)
      else $error("hit with bad row size");

   // No new request is taken while a response is pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while response pending");

   // A write beat never produces a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_WRITE |=> !rsp_valid)
      else $error("response after write");

endmodule

bind masked_key_row_address_lookup mkra_checker u_mkra_checker (.*);

### test/masked_key_row_address_lookup_tb.sv
// Self-checking testbench for the masked-key row address lookup.
module masked_key_row_address_lookup_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mkra_pkg::*;

   localparam int unsigned TABLE_DEPTH  = 16;
   localparam int unsigned HEADER_BYTES = 12;

   // Stop the random part once this many beats have gone in.
   localparam int ITEM_TARGET       = 700;
   // Hold rsp_ready low this long to back the block up into its input.
   localparam int LONG_STALL_CYCLES = 400;
   // Leave slack after the drain, beyond the worst lookup and its response beat.
   localparam int TAIL_CYCLES       = 40;
   // Generous bound on the whole run, far above the slowest correct one.
   localparam int CYCLE_LIMIT       = 400000;

   typedef struct packed {
      logic               hit;
      logic [KEY_W-1:0]   row_address;
      logic [BYTES_W-1:0] row_bytes;
   } row_result_type;

   // Receiver stall patterns, switched at random.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = CMD_WRITE;
   logic [SLOT_W-1:0]  req_entry_index = '0;
   logic [KEY_W-1:0]   req_entry_id = '0;
   logic [KEY_W-1:0]   req_entry_mask = '0;
   logic [KEY_W-1:0]   req_entry_base = '0;
   logic [WORDS_W-1:0] req_entry_row_words = '0;
   logic [KEY_W-1:0]   req_key = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [KEY_W-1:0]   rsp_row_address;
   logic [BYTES_W-1:0] rsp_row_bytes;

   // Shadow copy of the table and the lookups still owed by the block.
   entry_type      slot_table [TABLE_DEPTH];
   row_result_type pending_rows [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int burst_left     = 0;
   bit gaps_enabled   = 1'b1;

   // The long hold-off is requested by a test and timed by the stall process.
   int long_stall_request = 0;
   int long_stall_served  = 0;
   int long_stall_left    = 0;
   stall_mode_type stall_mode = READY_ALWAYS;
   int mode_left    = 0;
   int stall_phase  = 0;
   int cycle_count  = 0;

   masked_key_row_address_lookup #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_entry_index     (req_entry_index),
      .req_entry_id        (req_entry_id),
      .req_entry_mask      (req_entry_mask),
      .req_entry_base      (req_entry_base),
      .req_entry_row_words (req_entry_row_words),
      .req_key             (req_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_row_address     (rsp_row_address),
      .rsp_row_bytes       (rsp_row_bytes)
   );

   always #5 clock = ~clock;

   // Scan the shadow table the way the block does: stop at an end mark,
   // take the first masked match, and wrap the address at 32 bits.
   function automatic row_result_type compute_row_lookup(input logic [KEY_W-1:0] key);
      row_result_type     row;
      logic [KEY_W-1:0]   offset;
      logic [KEY_W-1:0]   stride;
      logic [KEY_W-1:0]   product;
      bit                 done;
      row  = '0;
      done = 1'b0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (!done) begin
            if (slot_table[s].id == END_MARK) begin
               done = 1'b1;
            end else if ((slot_table[s].mask & key) == slot_table[s].id) begin
               offset  = key & ~slot_table[s].mask;
               stride  = {20'd0, slot_table[s].row_words, 2'b00} + KEY_W'(HEADER_BYTES);
               product = offset * stride;
               row.hit         = 1'b1;
               row.row_address = slot_table[s].base + product;
               row.row_bytes   = ({3'd0, slot_table[s].row_words} + BYTES_W'(3)) << 2;
               done = 1'b1;
            end
         end
      end
      return row;
   endfunction

   // Drive one beat and hold it until the handshake; then update the shadow
   // table or queue the expected row. Close a burst with a random gap.
   task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] index,
                            input logic [KEY_W-1:0] id, input logic [KEY_W-1:0] mask,
                            input logic [KEY_W-1:0] base,
                            input logic [WORDS_W-1:0] row_words,
                            input logic [KEY_W-1:0] key);
      int gap;
      req_command         <= cmd;
      req_entry_index     <= index;
      req_entry_id        <= id;
      req_entry_mask      <= mask;
      req_entry_base      <= base;
      req_entry_row_words <= row_words;
      req_key             <= key;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_WRITE) begin
         if (index < TABLE_DEPTH)
            slot_table[index] = '{id: id, mask: mask, base: base, row_words: row_words};
      end else begin
         pending_rows.push_back(compute_row_lookup(key));
      end
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Fill the fields a command ignores with junk.
   task automatic send_write(input logic [SLOT_W-1:0] index, input logic [KEY_W-1:0] id,
                             input logic [KEY_W-1:0] mask, input logic [KEY_W-1:0] base,
                             input logic [WORDS_W-1:0] row_words);
      send_beat(CMD_WRITE, index, id, mask, base, row_words, $urandom);
   endtask

   task automatic send_lookup(input logic [KEY_W-1:0] key);
      send_beat(CMD_LOOKUP, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                WORDS_W'($urandom), key);
   endtask

   // Favor masks that leave useful offsets; all-zero masks shadow the rest, so keep them rare.
   function automatic logic [KEY_W-1:0] random_mask();
      logic [KEY_W-1:0] mask;
      case ($urandom_range(0, 9))
         0:       mask = '0;
         1, 2:    mask = '1;
         3, 4:    mask = '1 << $urandom_range(0, 31);
         5:       mask = '1 >> $urandom_range(0, 31);
         default: mask = $urandom;
      endcase
      return mask;
   endfunction

   function automatic logic [WORDS_W-1:0] random_row_words();
      logic [WORDS_W-1:0] words;
      case ($urandom_range(0, 7))
         0:       words = '0;
         1:       words = '1;
         default: words = $urandom_range(0, 1023);
      endcase
      return words;
   endfunction

   // Mostly matchable entries (id inside the mask), now and then a dead one.
   task automatic send_random_entry(input logic [SLOT_W-1:0] index);
      logic [KEY_W-1:0] mask;
      logic [KEY_W-1:0] id;
      mask = random_mask();
      id   = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : (KEY_W'($urandom) & mask);
      send_write(index, id, mask, $urandom, random_row_words());
   endtask

   // Write slots 0 to count-1 and usually close the table with an end mark.
   task automatic load_table(input int count);
      for (int s = 0; s < count; s++)
         send_random_entry(SLOT_W'(s));
      if (count < TABLE_DEPTH && $urandom_range(0, 9) < 7)
         send_write(SLOT_W'(count), END_MARK, $urandom, $urandom, random_row_words());
   endtask

   // Aim most keys at a slot of the shadow table, the rest anywhere.
   task automatic send_random_lookup();
      int               s;
      logic [KEY_W-1:0] key;
      s = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 7))
         0:       key = $urandom;
         1:       key = $urandom_range(0, 1) ? '0 : '1;
         default: key = (slot_table[s].id & slot_table[s].mask) | ($urandom & ~slot_table[s].mask);
      endcase
      send_lookup(key);
   endtask

   // Look up both extreme keys in the table left by reset.
   task automatic test_empty_table();
      send_lookup('0);
      send_lookup('1);
   endtask

   // An all-ones id ends the table even where its mask would match.
   task automatic test_end_marker();
      send_write('0, END_MARK, '1, 32'h0000_4000, 10'd5);
      send_lookup('1);
   endtask

   // Masked match with an offset, then the same entry at offset zero.
   task automatic test_masked_hits();
      send_write('0, 32'h1234_0000, 32'hffff_0000, 32'h0000_1000, 10'd0);
      send_lookup(32'h1234_abcd);
      send_lookup(32'h1234_0000);
   endtask

   // Fill every slot: hit the last one with a wrapping address, then slot 7;
   // then miss with no end mark anywhere.
   task automatic test_full_table();
      for (int s = 1; s < TABLE_DEPTH - 1; s++)
         send_write(SLOT_W'(s), 32'ha000_0000 + s, '1, $urandom, WORDS_W'(s));
      send_write(SLOT_W'(TABLE_DEPTH - 1), '0, '0, '1, '1);
      send_lookup('1);
      send_lookup(32'ha000_0007);
      send_write(SLOT_W'(TABLE_DEPTH - 1), 32'h5a5a_5a5a, '1, $urandom, '1);
      send_lookup(32'hdead_beef);
   endtask

   // Hold the receiver off and keep offering back-to-back beats, so the
   // block parks a response and stalls its input.
   task automatic test_backpressure();
      load_table($urandom_range(4, 10));
      gaps_enabled = 1'b0;
      long_stall_request++;
      repeat (40) begin
         if ($urandom_range(0, 7) == 0)
            send_random_entry(SLOT_W'($urandom));
         else
            send_random_lookup();
      end
      gaps_enabled = 1'b1;
   endtask

   // Reload the table in rounds and run lookups against it, with rewrites
   // slipped in, until the beat count is reached.
   task automatic test_random_tables();
      while (items_sent < ITEM_TARGET) begin
         load_table($urandom_range(1, TABLE_DEPTH));
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 9) == 0)
               send_random_entry(SLOT_W'($urandom));
            else
               send_random_lookup();
         end
      end
      gaps_enabled = 1'b1;
   endtask

   // Receiver: serve a requested long hold-off first, else follow the
   // current stall pattern.
   always @(posedge clock) begin
      if (long_stall_left > 0) begin
         rsp_ready <= 1'b0;
         long_stall_left--;
      end else if (long_stall_request != long_stall_served) begin
         long_stall_served = long_stall_request;
         long_stall_left   = LONG_STALL_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: rsp_ready <= (stall_phase % 4) != 0;
            READY_SPARSE:   rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Check each response beat against the oldest expected row.
   always @(posedge clock) begin : check_rows
      row_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            $display("%0t: response with none expected: hit=%0b address=%h bytes=%0d",
                     $time, rsp_hit, rsp_row_address, rsp_row_bytes);
            mismatch_count++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit mismatch: expected %0b, actual %0b",
                        $time, want.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_row_address !== want.row_address) begin
               $display("%0t: row_address mismatch: expected %h, actual %h",
                        $time, want.row_address, rsp_row_address);
               mismatch_count++;
            end
            if (rsp_row_bytes !== want.row_bytes) begin
               $display("%0t: row_bytes mismatch: expected %0d, actual %0d",
                        $time, want.row_bytes, rsp_row_bytes);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: count cycles and abort a run that never finishes.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : run_regression
      for (int s = 0; s < TABLE_DEPTH; s++)
         slot_table[s] = EMPTY_ENTRY;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_end_marker();
      test_masked_hits();
      test_full_table();
      test_backpressure();
      test_random_tables();

      // Drop valid, drain the owed rows, then watch for stray responses.
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
